>>> sv/sash_pkg.sv
// Shared constants and types for the sensor average with stale hold block.
`timescale 1ns / 1ps

package sash_pkg;

   // Averaging window and the widths that follow from it
   localparam int WINDOW     = 8;
   localparam int PTR_W      = $clog2(WINDOW);
   localparam int FILL_W     = PTR_W + 1;
   localparam int MV_W       = 16;
   localparam int SUM_W      = MV_W + PTR_W;
   localparam int DIV_CNT_W  = $clog2(MV_W);
   localparam int TIME_W     = 32;
   localparam int ENV_W      = 16;

   localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = 32'd1500;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_STALE = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_DLOAD,
      S_DIV,
      S_FIN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic sum_step;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic sum_last;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

>>> sv/sash_ctrl.sv
// Sequencing state machine: accept, sum, divide and result hand-off.
`timescale 1ns / 1ps

module sash_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_read_ok,
   output logic              req_ready,
   input  sash_pkg::sts_type sts,
   output sash_pkg::cmd_type cmd
);
   import sash_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = req_read_ok ? S_SUM : S_FIN;
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = S_DLOAD;
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold the result until the output register is free
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A transfer always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("controller stayed idle after an input transfer");

endmodule

>>> sv/sash_dp.sv
// Datapath: sample ring, sequenced sum, serial divider, snapshot and output register.
`timescale 1ns / 1ps

module sash_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sash_pkg::cmd_type                   cmd,
   output sash_pkg::sts_type                   sts,
   input  logic                                csr_wr_en,
   input  logic [sash_pkg::TIME_W-1:0]         csr_wr_data,
   input  logic                                req_read_ok,
   input  logic [sash_pkg::MV_W-1:0]           req_sample_mv,
   input  logic signed [sash_pkg::ENV_W-1:0]   req_temp_in,
   input  logic signed [sash_pkg::ENV_W-1:0]   req_humidity_in,
   input  logic [sash_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [sash_pkg::MV_W-1:0]           rsp_avg_mv,
   output logic signed [sash_pkg::ENV_W-1:0]   rsp_temp_out,
   output logic signed [sash_pkg::ENV_W-1:0]   rsp_humidity_out,
   output logic                                rsp_snap_valid,
   output logic [sash_pkg::TIME_W-1:0]         rsp_snap_time_ms
);
   import sash_pkg::*;

   // Configuration
   logic [TIME_W-1:0] stale_limit_ff;

   // Ring and its pointers
   logic [MV_W-1:0]   ring_ff [WINDOW];
   logic [PTR_W-1:0]  wpos_ff;
   logic [FILL_W-1:0] fill_ff;

   // Latched poll
   logic                    ok_ff;
   logic signed [ENV_W-1:0] temp_ff;
   logic signed [ENV_W-1:0] hum_ff;
   logic [TIME_W-1:0]       now_ff;

   // Sum and divider
   logic [PTR_W-1:0]     idx_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic [PTR_W-1:0]     rem_ff;
   logic [MV_W-1:0]      quo_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [PTR_W:0]       trial;
   logic                 trial_ge;

   // Snapshot
   logic [MV_W-1:0]         last_avg_ff;
   logic signed [ENV_W-1:0] last_temp_ff;
   logic signed [ENV_W-1:0] last_hum_ff;
   logic                    last_valid_ff;
   logic [TIME_W-1:0]       last_time_ff;

   // Output register
   logic                    out_valid_ff;
   status_type              out_status_ff;
   logic [MV_W-1:0]         out_avg_ff;
   logic signed [ENV_W-1:0] out_temp_ff;
   logic signed [ENV_W-1:0] out_hum_ff;
   logic                    out_snap_valid_ff;
   logic [TIME_W-1:0]       out_time_ff;

   // Result of the current poll
   logic [TIME_W-1:0] age;
   logic              fresh;
   status_type        new_status;
   logic              new_valid;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         stale_limit_ff <= csr_wr_data;
      end
   end

   // Ring write on a successful transfer
   always_ff @(posedge clock) begin
      if (cmd.accept && req_read_ok) begin
         ring_ff[wpos_ff] <= req_sample_mv;
      end
   end

   // Ring pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.accept && req_read_ok) begin
         wpos_ff <= wpos_ff + PTR_W'(1);
         if (fill_ff != FILL_W'(WINDOW)) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end
      end
   end

   // Latch the poll fields
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ok_ff   <= req_read_ok;
         temp_ff <= req_temp_in;
         hum_ff  <= req_humidity_in;
         now_ff  <= req_now_ms;
      end
   end

   // Sum the filled entries, one a cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.sum_step) begin
         idx_ff <= idx_ff + PTR_W'(1);
         acc_ff <= acc_ff + SUM_W'(ring_ff[idx_ff]);
      end
   end

   // Restoring divide by the fill count, one quotient bit a cycle
   assign trial    = {rem_ff, quo_ff[MV_W-1]};
   assign trial_ge = (trial >= fill_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= acc_ff[SUM_W-1:MV_W];
         quo_ff  <= acc_ff[MV_W-1:0];
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? PTR_W'(trial - fill_ff) : trial[PTR_W-1:0];
         quo_ff  <= {quo_ff[MV_W-2:0], trial_ge};
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
   end

   // Decide the status of this poll
   assign age   = now_ff - last_time_ff;
   assign fresh = last_valid_ff && (age <= stale_limit_ff);

   always_comb begin
      priority if (ok_ff) begin
         new_status = ST_OK;
         new_valid  = 1'b1;
      end else if (fresh) begin
         new_status = ST_STALE;
         new_valid  = 1'b1;
      end else begin
         new_status = ST_ERROR;
         new_valid  = 1'b0;
      end
   end

   // Update the snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         last_avg_ff   <= '0;
         last_temp_ff  <= '0;
         last_hum_ff   <= '0;
         last_valid_ff <= 1'b0;
         last_time_ff  <= '0;
      end else if (cmd.finish) begin
         last_valid_ff <= new_valid;
         if (ok_ff) begin
            last_avg_ff  <= quo_ff;
            last_temp_ff <= temp_ff;
            last_hum_ff  <= hum_ff;
            last_time_ff <= now_ff;
         end
      end
   end

   // Output register: load on finish, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_status_ff     <= new_status;
         out_snap_valid_ff <= new_valid;
         out_avg_ff        <= ok_ff ? quo_ff  : last_avg_ff;
         out_temp_ff       <= ok_ff ? temp_ff : last_temp_ff;
         out_hum_ff        <= ok_ff ? hum_ff  : last_hum_ff;
         out_time_ff       <= ok_ff ? now_ff  : last_time_ff;
      end
   end

   // Status to the controller
   assign sts.sum_last = ({1'b0, idx_ff} == (fill_ff - FILL_W'(1)));
   assign sts.div_last = (dcnt_ff == DIV_CNT_W'(MV_W - 1));
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_avg_mv       = out_avg_ff;
   assign rsp_temp_out     = out_temp_ff;
   assign rsp_humidity_out = out_hum_ff;
   assign rsp_snap_valid   = out_snap_valid_ff;
   assign rsp_snap_time_ms = out_time_ff;

   // Fill count never passes the window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill count beyond window");

   // Summing only happens over written entries
   a_sum_filled: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_step |-> (fill_ff != '0) && ({1'b0, idx_ff} < fill_ff))
      else $error("sum reads an unfilled ring entry");

   // Error results carry a cleared valid mark, the others a set one
   a_status_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_status_ff == ST_ERROR) == !out_snap_valid_ff))
      else $error("status and snapshot valid mark disagree");

   // A finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.finish)
      else $error("pending result overwritten");

endmodule

>>> sv/sensor_average_with_stale_hold_core.sv
// Top level of the sensor average with stale hold block.
// Each poll arrives on the req_ channel (valid/ready): read flag, millivolt
// sample, temperature, humidity and current millisecond time. One result per
// poll leaves on the rsp_ channel (valid/ready): status, averaged millivolts,
// stored temperature and humidity, snapshot valid mark and snapshot time.
// csr_wr_en/csr_wr_data write the stale limit in ms (reset value 1500).
// A successful read enters an 8-entry ring; the filled entries are summed one
// per cycle and divided by the fill count in a bit-serial divider of 16 steps.
// A successful read goes through the sum, divider-load, divide and finish
// states (fill count 1 to 8); a failed read goes straight to the finish state.
// One poll is worked on at a time; a new poll can be taken in the cycle after
// its result is loaded into the output register.
// Results sit in an output register: the next poll is taken and worked on
// while a result waits; only loading the following result waits for rsp_ready.
// Reset clears the ring pointer, fill count, snapshot and output valid and
// restores the stale limit.
`timescale 1ns / 1ps

module sensor_average_with_stale_hold_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sash_pkg::TIME_W-1:0]         csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_read_ok,
   input  logic [sash_pkg::MV_W-1:0]           req_sample_mv,
   input  logic signed [sash_pkg::ENV_W-1:0]   req_temp_in,
   input  logic signed [sash_pkg::ENV_W-1:0]   req_humidity_in,
   input  logic [sash_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [sash_pkg::MV_W-1:0]           rsp_avg_mv,
   output logic signed [sash_pkg::ENV_W-1:0]   rsp_temp_out,
   output logic signed [sash_pkg::ENV_W-1:0]   rsp_humidity_out,
   output logic                                rsp_snap_valid,
   output logic [sash_pkg::TIME_W-1:0]         rsp_snap_time_ms
);
   import sash_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   sash_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_read_ok (req_read_ok),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Datapath
   sash_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_read_ok      (req_read_ok),
      .req_sample_mv    (req_sample_mv),
      .req_temp_in      (req_temp_in),
      .req_humidity_in  (req_humidity_in),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_avg_mv       (rsp_avg_mv),
      .rsp_temp_out     (rsp_temp_out),
      .rsp_humidity_out (rsp_humidity_out),
      .rsp_snap_valid   (rsp_snap_valid),
      .rsp_snap_time_ms (rsp_snap_time_ms)
   );

endmodule

>>> dv/sensor_average_with_stale_hold_core_tb.sv
// Self-checking testbench for the sensor average with stale hold core.
`timescale 1ns / 1ps

module sensor_average_with_stale_hold_core_tb;
   import sash_pkg::*;

   // One poll as offered on the request channel
   typedef struct {
      logic                    read_ok;
      logic [MV_W-1:0]         sample_mv;
      logic signed [ENV_W-1:0] temp_in;
      logic signed [ENV_W-1:0] humidity_in;
      logic [TIME_W-1:0]       now_ms;
   } poll_type;

   // One snapshot as returned on the response channel
   typedef struct {
      status_type              status;
      logic [MV_W-1:0]         avg_mv;
      logic signed [ENV_W-1:0] temp_out;
      logic signed [ENV_W-1:0] humidity_out;
      logic                    snap_valid;
      logic [TIME_W-1:0]       snap_time_ms;
   } snap_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    csr_wr_en = 1'b0;
   logic [TIME_W-1:0]       csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_read_ok = 1'b0;
   logic [MV_W-1:0]         req_sample_mv = '0;
   logic signed [ENV_W-1:0] req_temp_in = '0;
   logic signed [ENV_W-1:0] req_humidity_in = '0;
   logic [TIME_W-1:0]       req_now_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [MV_W-1:0]         rsp_avg_mv;
   logic signed [ENV_W-1:0] rsp_temp_out;
   logic signed [ENV_W-1:0] rsp_humidity_out;
   logic                    rsp_snap_valid;
   logic [TIME_W-1:0]       rsp_snap_time_ms;

   sensor_average_with_stale_hold_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_read_ok      (req_read_ok),
      .req_sample_mv    (req_sample_mv),
      .req_temp_in      (req_temp_in),
      .req_humidity_in  (req_humidity_in),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_avg_mv       (rsp_avg_mv),
      .rsp_temp_out     (rsp_temp_out),
      .rsp_humidity_out (rsp_humidity_out),
      .rsp_snap_valid   (rsp_snap_valid),
      .rsp_snap_time_ms (rsp_snap_time_ms)
   );

   // Free-running clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Filter state mirrored by the testbench
   logic [MV_W-1:0]         mv_ring [0:WINDOW-1];
   logic [PTR_W-1:0]        ring_wr = '0;
   logic [FILL_W-1:0]       ring_fill = '0;
   logic [MV_W-1:0]         snap_avg = '0;
   logic signed [ENV_W-1:0] snap_temp = '0;
   logic signed [ENV_W-1:0] snap_hum = '0;
   logic                    snap_ok = 1'b0;
   logic [TIME_W-1:0]       snap_time = '0;
   logic [TIME_W-1:0]       stale_limit = STALE_LIMIT_RESET;

   poll_type pending_polls[$];
   snap_type expected_snapshots[$];
   poll_type poll_cur;

   int unsigned polls_accepted = 0;
   int unsigned snaps_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned count_ok = 0;
   int unsigned count_stale = 0;
   int unsigned count_error = 0;
   int unsigned limit_settings = 1;
   int unsigned src_gap = 0;
   int unsigned src_calm = 0;
   int unsigned sink_stall = 0;
   int unsigned sink_calm = 0;
   logic        sink_hold = 1'b0;

   // Stimulus time base: running clock and time of the last good read
   logic [TIME_W-1:0] gen_clock_ms = '0;
   logic [TIME_W-1:0] gen_anchor_ms = '0;

   // Apply one poll to the mirrored filter and return the snapshot it yields
   function automatic snap_type advance_filter(poll_type p);
      snap_type    s;
      int unsigned total;
      if (p.read_ok) begin
         mv_ring[ring_wr] = p.sample_mv;
         ring_wr = ring_wr + 1'b1;
         if (ring_fill < WINDOW) ring_fill = ring_fill + 1'b1;
         total = 0;
         for (int i = 0; i < ring_fill; i++) total += mv_ring[i];
         snap_avg  = MV_W'(total / ring_fill);
         snap_temp = p.temp_in;
         snap_hum  = p.humidity_in;
         snap_ok   = 1'b1;
         snap_time = p.now_ms;
         s.status  = ST_OK;
      end else if (snap_ok && (p.now_ms - snap_time) <= stale_limit) begin
         s.status = ST_STALE;
      end else begin
         snap_ok  = 1'b0;
         s.status = ST_ERROR;
      end
      s.avg_mv       = snap_avg;
      s.temp_out     = snap_temp;
      s.humidity_out = snap_hum;
      s.snap_valid   = snap_ok;
      s.snap_time_ms = snap_time;
      return s;
   endfunction

   // Idle length: mostly short, a few long, with runs of back-to-back traffic
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                  logic [TIME_W-1:0] want);
      $display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, snaps_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_poll(logic ok, logic [MV_W-1:0] mv, logic signed [ENV_W-1:0] t,
                             logic signed [ENV_W-1:0] h, logic [TIME_W-1:0] now);
      poll_type p;
      p.read_ok     = ok;
      p.sample_mv   = mv;
      p.temp_in     = t;
      p.humidity_in = h;
      p.now_ms      = now;
      pending_polls.push_back(p);
   endtask

   // Random poll; failed reads land around the stale limit of the last good read
   function automatic poll_type random_poll();
      poll_type          p;
      logic [TIME_W-1:0] age;
      p.read_ok = ($urandom_range(0, 99) < 55);
      case ($urandom_range(0, 9))
         0:       p.sample_mv = '0;
         1:       p.sample_mv = '1;
         default: p.sample_mv = MV_W'($urandom);
      endcase
      p.temp_in     = ENV_W'($urandom);
      p.humidity_in = ENV_W'($urandom);
      if (p.read_ok) begin
         if ($urandom_range(0, 19) == 0) gen_clock_ms = $urandom;
         else gen_clock_ms = gen_clock_ms + $urandom_range(0, 3000);
         gen_anchor_ms = gen_clock_ms;
         p.now_ms = gen_clock_ms;
      end else begin
         case ($urandom_range(0, 7))
            0:       age = '0;
            1:       age = stale_limit;
            2:       age = stale_limit + 1'b1;
            3:       age = stale_limit - 1'b1;
            4:       age = $urandom_range(0, stale_limit);
            5:       age = $urandom;
            6:       age = -$urandom_range(1, 5000);
            default: age = $urandom_range(0, 3000);
         endcase
         p.now_ms = gen_anchor_ms + age;
         gen_clock_ms = p.now_ms;
      end
      return p;
   endfunction

   // Request driver: hold each poll until its transfer, then idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_read_ok     <= 1'b0;
         req_sample_mv   <= '0;
         req_temp_in     <= '0;
         req_humidity_in <= '0;
         req_now_ms      <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_snapshots.push_back(advance_filter(poll_cur));
            polls_accepted++;
            src_gap = pick_gap(src_calm);
         end
         if (!req_valid || req_ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
               poll_cur = pending_polls.pop_front();
               req_valid       <= 1'b1;
               req_read_ok     <= poll_cur.read_ok;
               req_sample_mv   <= poll_cur.sample_mv;
               req_temp_in     <= poll_cur.temp_in;
               req_humidity_in <= poll_cur.humidity_in;
               req_now_ms      <= poll_cur.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest expected snapshot
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_snapshots.size() == 0) begin
               report_mismatch("unexpected result, status", TIME_W'(rsp_status), '0);
            end else begin
               case (expected_snapshots[0].status)
                  ST_OK:    count_ok++;
                  ST_STALE: count_stale++;
                  default:  count_error++;
               endcase
               if (rsp_status !== expected_snapshots[0].status)
                  report_mismatch("status", TIME_W'(rsp_status),
                                  TIME_W'(expected_snapshots[0].status));
               if (rsp_avg_mv !== expected_snapshots[0].avg_mv)
                  report_mismatch("avg_mv", TIME_W'(rsp_avg_mv),
                                  TIME_W'(expected_snapshots[0].avg_mv));
               if (rsp_temp_out !== expected_snapshots[0].temp_out)
                  report_mismatch("temp_out", TIME_W'(rsp_temp_out),
                                  TIME_W'(expected_snapshots[0].temp_out));
               if (rsp_humidity_out !== expected_snapshots[0].humidity_out)
                  report_mismatch("humidity_out", TIME_W'(rsp_humidity_out),
                                  TIME_W'(expected_snapshots[0].humidity_out));
               if (rsp_snap_valid !== expected_snapshots[0].snap_valid)
                  report_mismatch("snap_valid", TIME_W'(rsp_snap_valid),
                                  TIME_W'(expected_snapshots[0].snap_valid));
               if (rsp_snap_time_ms !== expected_snapshots[0].snap_time_ms)
                  report_mismatch("snap_time_ms", rsp_snap_time_ms,
                                  expected_snapshots[0].snap_time_ms);
               void'(expected_snapshots.pop_front());
            end
            snaps_checked++;
            sink_stall = pick_gap(sink_calm);
         end
         if (sink_hold) begin
            rsp_ready <= 1'b0;
         end else if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off mid-run while polls keep coming
   initial begin
      wait (polls_accepted >= 600);
      @(posedge clock);
      sink_hold <= 1'b1;
      repeat (300) @(posedge clock);
      sink_hold <= 1'b0;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_polls.size() != 0 || req_valid || expected_snapshots.size() != 0);
   endtask

   task automatic write_stale_limit(logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      stale_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_settings++;
   endtask

   task automatic run_random_phase(int unsigned n);
      @(negedge clock);
      repeat (n) pending_polls.push_back(random_poll());
      wait_drained();
   endtask

   // Sequencer: directed polls, then random phases over several stale limits
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // failed reads before any good read give zeroed error snapshots
      queue_poll(1'b0, 16'h1234, 0, 0, 32'h0);
      queue_poll(1'b0, 16'hFFFF, -1, -1, 32'hFFFF_FFFF);
      // first good read, then zero age, age at the limit and one past it
      queue_poll(1'b1, 16'hFFFF, -32768, 32767, 32'd1000);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd1000);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd2500);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd2501);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd2400);
      // fill the ring with full-scale samples, then wrap it
      queue_poll(1'b1, 16'hFFFF, 32767, -32768, 32'd3000);
      for (int i = 1; i <= 6; i++)
         queue_poll(1'b1, 16'hFFFF, ENV_W'(-i), ENV_W'(i), 32'd3000 + i);
      queue_poll(1'b1, 16'h0000, 0, 0, 32'd3007);
      queue_poll(1'b1, 16'h8000, -1, -1, 32'd3008);
      queue_poll(1'b1, 16'h0001, 1, 1, 32'd5000);
      // time going backwards
      queue_poll(1'b0, 16'h0, 0, 0, 32'd4999);
      // millisecond counter wrapping past zero
      queue_poll(1'b1, 16'h0000, 100, 200, 32'hFFFF_FF00);
      queue_poll(1'b0, 16'h0, 0, 0, 32'h0000_0100);
      queue_poll(1'b0, 16'h0, 0, 0, 32'hFFFF_FEFF);
      queue_poll(1'b1, 16'hAAAA, 16'sh5555, -21846, 32'hFFFF_FFFF);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd1499);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd1500);
      wait_drained();

      // zero limit: only zero age keeps the snapshot
      write_stale_limit('0);
      @(negedge clock);
      queue_poll(1'b1, 16'h0042, 7, 7, 32'd7);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd7);
      queue_poll(1'b0, 16'h0, 0, 0, 32'd8);
      gen_clock_ms = 32'd8;
      gen_anchor_ms = 32'd7;
      run_random_phase(250);

      write_stale_limit('1);
      run_random_phase(250);

      write_stale_limit(32'd200);
      run_random_phase(300);

      write_stale_limit($urandom_range(1, 100000));
      run_random_phase(200);

      write_stale_limit(STALE_LIMIT_RESET);
      run_random_phase(150);

      repeat (40) @(posedge clock);

      $display("Checked %0d snapshots from %0d polls over %0d stale limit settings",
               snaps_checked, polls_accepted, limit_settings);
      $display("Statuses seen: %0d ok, %0d stale, %0d error; %0d mismatches",
               count_ok, count_stale, count_error, mismatch_count);
      if (mismatch_count == 0 && expected_snapshots.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
